### design/tllm_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the truncated linear label message block.
// Used by the channel interfaces, the accumulator cell and the top level.
package tllm_pkg;

  // Default number of labels per pixel.
  localparam int LabelsDef = 64;

  // Field widths.
  localparam int LABEL_W = 6;
  localparam int MSG_W   = 32;
  localparam int VALUE_W = 56;
  localparam int CFG_W   = 16;

  // Distance times weight: 6 bits by 16 bits.
  localparam int RAW_W  = LABEL_W + CFG_W;
  // Unsigned 16-bit cost, with a zero sign bit, times a signed 32-bit message.
  localparam int PROD_W = CFG_W + 1 + MSG_W;

  // APB register port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register indexes (byte address divided by four).
  localparam logic [0:0] REG_WEIGHT = 1'b0;
  localparam logic [0:0] REG_TRUNC  = 1'b1;

  // Register reset values, unsigned Q8.8.
  localparam logic [CFG_W-1:0] WEIGHT_RST = 16'd256;
  localparam logic [CFG_W-1:0] TRUNC_RST  = 16'd512;

  // One message word travelling down the row of cells.
  typedef struct packed {
    logic                     valid;
    logic [LABEL_W-1:0]       label;
    logic signed [MSG_W-1:0]  msg;
  } token_t;

  // Configuration handed to every cell.
  typedef struct packed {
    logic [CFG_W-1:0] weight;
    logic [CFG_W-1:0] trunc;
  } cell_cfg_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic shift;
  } cell_ctrl_t;

  // Status from a cell back to the sequencer.
  typedef struct packed {
    logic busy;
  } cell_stat_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_FLUSH = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

endpackage

### design/tllm_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one label message word.
// Depends on tllm_pkg for the field width.
interface tllm_in_if
  import tllm_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [MSG_W-1:0] label_value;

  modport source (output valid, output label_value, input ready);
  modport sink (input valid, input label_value, output ready);
endinterface

### design/tllm_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one transformed label result word.
// Depends on tllm_pkg for the field widths.
interface tllm_out_if
  import tllm_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic [LABEL_W-1:0]        out_label;
  logic                      last_label;

  modport source (output valid, output out_value, output out_label, output last_label,
                  input ready);
  modport sink (input valid, input out_value, input out_label, input last_label,
                output ready);
endinterface

### design/truncated_linear_label_message.sv
`timescale 1ns / 1ps
// Top level of the truncated linear label compatibility transform.
// Depends on tllm_pkg, tllm_in_if, tllm_out_if and tllm_cell.
//
//   Port      Direction  Word
//   in_i      sink       one label message, labels 0 to LABELS-1 in order
//   out_o     source     one summed result, labels 0 to LABELS-1, last marked
//   APB       slave      label_weight at 0x0, cost_truncation at 0x4
//
// A pixel loads one message per cycle while the sender offers them, then waits
// while the last message walks down the row of cells and through the last
// cell's cost and product stages, then shifts the sums out, one per cycle while
// the output is taken. Input is refused while the row flushes and drains. Reset
// clears the row's sums and the label counter. A stalled output holds its word
// and stops the drain.
module truncated_linear_label_message
  import tllm_pkg::*;
#(
  parameter int LABELS = LabelsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tllm_in_if.sink               in_i,
  tllm_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [LABEL_W-1:0] LastLabel = LABEL_W'(LABELS - 1);

  state_e             state_q, state_d;
  logic [LABEL_W-1:0] count_q, count_d;
  logic [CFG_W-1:0]   weight_q;
  logic [CFG_W-1:0]   trunc_q;

  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_value_q;
  logic [LABEL_W-1:0]        out_label_q;
  logic                      last_q;

  logic                      in_fire;
  logic                      out_load;
  logic                      chain_busy;
  logic [0:0]                reg_idx;
  cell_cfg_t                 cell_cfg;
  cell_ctrl_t                cell_ctrl;
  token_t                    tok_w [LABELS+1];
  logic signed [VALUE_W-1:0] acc_w [LABELS+1];
  cell_stat_t                stat_w [LABELS];

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RST;
      trunc_q  <= TRUNC_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WEIGHT: weight_q <= pwdata[CFG_W-1:0];
        REG_TRUNC:  trunc_q  <= pwdata[CFG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WEIGHT: prdata = APB_DATA_W'(weight_q);
      REG_TRUNC:  prdata = APB_DATA_W'(trunc_q);
      default:    prdata = '0;
    endcase
  end

  assign cell_cfg.weight = weight_q;
  assign cell_cfg.trunc  = trunc_q;

  // Row of accumulator cells; messages enter at cell 0, sums leave at cell 0.
  assign in_i.ready   = (state_q == ST_LOAD);
  assign in_fire      = in_i.valid && in_i.ready;
  assign tok_w[0].valid = in_fire;
  assign tok_w[0].label = count_q;
  assign tok_w[0].msg   = in_i.label_value;
  assign acc_w[LABELS]  = '0;

  for (genvar g = 0; g < LABELS; g++) begin : g_cell
    tllm_cell #(
      .LABEL_IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (cell_cfg),
      .ctrl_i (cell_ctrl),
      .tok_i  (tok_w[g]),
      .tok_o  (tok_w[g+1]),
      .acc_i  (acc_w[g+1]),
      .acc_o  (acc_w[g]),
      .stat_o (stat_w[g])
    );
  end

  always_comb begin
    chain_busy = 1'b0;
    for (int i = 0; i < LABELS; i++) begin
      chain_busy = chain_busy | stat_w[i].busy;
    end
  end

  // Sequencer: load messages, wait for the row to settle, drain the sums.
  assign out_load        = (state_q == ST_DRAIN) && (!out_valid_q || out_o.ready);
  assign cell_ctrl.shift = out_load;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (count_q == LastLabel) begin
            count_d = '0;
            state_d = ST_FLUSH;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!chain_busy) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (count_q == LastLabel) begin
            count_d = '0;
            state_d = ST_LOAD;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register, loaded from the head of the row.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= acc_w[0];
      out_label_q <= count_q;
      last_q      <= (count_q == LastLabel);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_value  = out_value_q;
  assign out_o.out_label  = out_label_q;
  assign out_o.last_label = last_q;

  // The drain only starts once no product is still on its way to a sum.
  a_drain_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> !chain_busy)
    else $error("drain started while the cell row still held products");

  // A new pixel starts on cleared sums.
  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && count_q == '0) |-> (acc_w[0] == '0))
    else $error("row sums not cleared at the start of a pixel");

  // The marked word is the one for the final label.
  a_last_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_label) |-> (out_o.out_label == LastLabel))
    else $error("last marker on a word that is not the final label");

endmodule

### design/tllm_cell.sv
`timescale 1ns / 1ps
// One accumulator cell of the row: owns the sum for a single output label.
// Depends on tllm_pkg for the token, configuration and status types.
module tllm_cell
  import tllm_pkg::*;
#(
  parameter int LABEL_IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cell_cfg_t                 cfg_i,
  input  cell_ctrl_t                ctrl_i,
  input  token_t                    tok_i,
  output token_t                    tok_o,
  input  logic signed [VALUE_W-1:0] acc_i,
  output logic signed [VALUE_W-1:0] acc_o,
  output cell_stat_t                stat_o
);

  localparam logic [LABEL_W-1:0] MyLabel = LABEL_W'(LABEL_IDX);

  token_t                    tok_q;
  logic                      a_valid_q;
  logic [CFG_W-1:0]          cost_q;
  logic signed [MSG_W-1:0]   msg_q;
  logic                      b_valid_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [VALUE_W-1:0] acc_q;

  logic [LABEL_W-1:0] lbl_dist;
  logic [RAW_W-1:0]   raw_cost;
  logic [CFG_W-1:0]   cost_d;

  // Token register: the word moves one cell further each cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign tok_o = tok_q;

  // Pairwise cost: label distance times weight, clamped to the truncation.
  always_comb begin
    lbl_dist = (tok_q.label >= MyLabel) ? (tok_q.label - MyLabel) : (MyLabel - tok_q.label);
    raw_cost = RAW_W'(lbl_dist) * RAW_W'(cfg_i.weight);
    cost_d   = (raw_cost > RAW_W'(cfg_i.trunc)) ? cfg_i.trunc : raw_cost[CFG_W-1:0];
  end

  // Stage A holds the cost and the message, stage B their product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= tok_q.valid;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cost_q <= cost_d;
    msg_q  <= tok_q.msg;
    prod_q <= $signed({1'b0, cost_q}) * msg_q;
  end

  // Accumulator: adds products while loading, shifts toward the output while
  // draining. The sum of all products stays well inside 56 bits, so it never
  // needs saturating.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.shift) begin
      acc_q <= acc_i;
    end else if (b_valid_q) begin
      acc_q <= acc_q + {{(VALUE_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign acc_o       = acc_q;
  assign stat_o.busy = tok_q.valid | a_valid_q | b_valid_q;

endmodule

### test/tllm_transform_check.sv
`timescale 1ns / 1ps
// Watches the label message channels and the APB port, predicts every summed result and
// compares it field by field. Depends on tllm_pkg, tllm_in_if and tllm_out_if.
module tllm_transform_check
  import tllm_pkg::*;
#(
  parameter int LABELS = LabelsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tllm_in_if                    in_mon,
  tllm_out_if                   out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    pending_o,
  output int                    mismatches_o
);

  localparam longint ValueMax = (longint'(1) << (VALUE_W - 1)) - 1;
  localparam longint ValueMin = -ValueMax - 1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [LABEL_W-1:0]        label;
    logic                      last;
  } label_sum_t;

  logic signed [MSG_W-1:0] pixel_msgs [LABELS];
  logic [LABEL_W-1:0]      label_count;
  logic [CFG_W-1:0]        label_weight;
  logic [CFG_W-1:0]        cost_trunc;
  label_sum_t              pending_sums [$];
  int                      mismatch_count;

  assign mismatches_o = mismatch_count;

  // Prints one line for a mismatch and counts it.
  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("checker: %s (at %0t)", what, $time);
  endtask

  // Forms the truncated linear cost sum for every output label of the stored pixel.
  function automatic void transform_pixel();
    int                 lbl_dist;
    logic [RAW_W-1:0]   raw;
    logic [CFG_W-1:0]   cost;
    longint             sum;
    label_sum_t         res;
    for (int l = 0; l < LABELS; l++) begin
      sum = 0;
      for (int r = 0; r < LABELS; r++) begin
        lbl_dist = (r > l) ? r - l : l - r;
        raw  = RAW_W'(lbl_dist) * RAW_W'(label_weight);
        cost = (raw > RAW_W'(cost_trunc)) ? cost_trunc : CFG_W'(raw);
        sum += longint'(cost) * longint'(pixel_msgs[r]);
      end
      // Saturation at the 56-bit range; unreachable at these widths but kept exact.
      if (sum > ValueMax) sum = ValueMax;
      if (sum < ValueMin) sum = ValueMin;
      res.value = sum[VALUE_W-1:0];
      res.label = LABEL_W'(l);
      res.last  = (l == LABELS - 1);
      pending_sums.push_back(res);
    end
  endfunction

  // Tracks register writes, stores message words, and checks every result word taken.
  always @(posedge clk_i or negedge rst_ni) begin
    label_sum_t want;
    if (!rst_ni) begin
      label_count    = '0;
      label_weight   = WEIGHT_RST;
      cost_trunc     = TRUNC_RST;
      mismatch_count = 0;
      pending_sums.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_WEIGHT: label_weight = pwdata[CFG_W-1:0];
          REG_TRUNC:  cost_trunc   = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        pixel_msgs[label_count] = in_mon.label_value;
        if (label_count == LABEL_W'(LABELS - 1)) begin
          label_count = '0;
          transform_pixel();
        end else begin
          label_count++;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_sums.size() == 0) begin
          flag_mismatch($sformatf("result word for label %0d with nothing expected",
                                  out_mon.out_label));
        end else begin
          want = pending_sums.pop_front();
          if (out_mon.out_value !== want.value) begin
            flag_mismatch($sformatf("label %0d value %h, expected %h",
                                    want.label, out_mon.out_value, want.value));
          end
          if (out_mon.out_label !== want.label) begin
            flag_mismatch($sformatf("label index %0d, expected %0d",
                                    out_mon.out_label, want.label));
          end
          if (out_mon.last_label !== want.last) begin
            flag_mismatch($sformatf("label %0d last flag %b, expected %b",
                                    want.label, out_mon.last_label, want.last));
          end
        end
      end
      pending_o <= pending_sums.size();
    end
  end

endmodule

### test/tb_truncated_linear_label_message.sv
`timescale 1ns / 1ps
// Top of the label message transform bench: clock, reset, APB writes, message words and
// output stalls. Depends on tllm_pkg, both channel interfaces and tllm_transform_check.
module tb_truncated_linear_label_message;
  import tllm_pkg::*;

  localparam int LABELS    = LabelsDef;
  localparam int DrainWait = LABELS + 8;

  typedef enum int {
    FILL_DIRECTED,
    FILL_EXTREME,
    FILL_RANDOM
  } fill_e;

  // Field extremes and bit patterns that open the first pixel.
  localparam logic [MSG_W-1:0] DirectedWords [14] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_8000
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    gap_pct;
  int                    stall_pct;
  int                    pending;
  int                    mismatches;

  tllm_in_if  in_if ();
  tllm_out_if out_if ();

  truncated_linear_label_message #(
    .LABELS(LABELS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  tllm_transform_check #(
    .LABELS(LABELS)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #200_000;
    $display("tb: failure");
    $finish;
  end

  // Output side: takes a word or stalls, one decision per cycle.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Register write: setup cycle, then access cycle; upper data bits are junk on purpose.
  task automatic apb_write(input logic [0:0] index, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offers one message word, maybe after a short gap, and returns once it is taken.
  task automatic send_word(input logic [MSG_W-1:0] word);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.label_value <= word;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Sends a whole pixel, then waits for all its sums and lets the row settle. The sender
  // idling changes halfway through the load and the receiver stalling halfway through the
  // drain.
  task automatic send_pixel(input fill_e fill, input int gap_lo, input int gap_hi,
                            input int stall_lo, input int stall_hi);
    logic [MSG_W-1:0] word;
    for (int i = 0; i < LABELS; i++) begin
      gap_pct = (i < LABELS / 2) ? gap_lo : gap_hi;
      word = $urandom;
      if (fill == FILL_DIRECTED && i < $size(DirectedWords)) begin
        word = DirectedWords[i];
      end else if (fill == FILL_EXTREME && $urandom_range(0, 9) != 0) begin
        word = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      send_word(word);
    end
    in_if.valid <= 1'b0;
    stall_pct = stall_lo;
    @(posedge clk_i);
    while (pending > LABELS / 2) @(posedge clk_i);
    stall_pct = stall_hi;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.label_value = '0;
    gap_pct           = 0;
    stall_pct         = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset weights, directed words first, no idling.
    send_pixel(FILL_DIRECTED, 0, 0, 0, 0);

    // Largest weight and clamp with extreme messages: sender idling through the load, then
    // receiver stalling through the drain, both easing off halfway.
    apb_write(REG_WEIGHT, 16'hFFFF);
    apb_write(REG_TRUNC, 16'hFFFF);
    send_pixel(FILL_EXTREME, 52, 22, 52, 22);

    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
